[design/fqp_pkg.sv]
// Shared types and constants for the FASTQ record parser.
// Holds the result kind codes, the character codes and the beat struct
// that the parse core hands to the output stage. No dependencies.
`default_nettype none

package fqp_pkg;

    // Default width of the sequence and quality length counters
    localparam int LENGTH_BITS_DEF = 16;

    // Character codes the parser looks for
    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Result kind codes
    typedef enum logic [2:0] {
        K_ID = 3'd0,
        K_SEQ = 3'd1,
        K_QUAL = 3'd2,
        K_END = 3'd3,
        K_DONE = 3'd4,
        K_ERR = 3'd5
    } t_kind;

    // One result beat from the parse core to the output stage
    typedef struct packed {
        logic valid;
        t_kind kind;
        logic [7:0] char_out;
        logic length_mismatch;
    } t_res_beat;

endpackage

`default_nettype wire

[design/fqp_in_if.sv]
// Input channel of the FASTQ record parser: one text byte or an
// end-of-input mark per beat, valid/ready handshake. No dependencies.
`default_nettype none

interface fqp_in_if;
    logic valid;
    logic ready;
    logic [7:0] byte_in;
    logic end_of_input;

    modport source (output valid, output byte_in, output end_of_input, input ready);
    modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

`default_nettype wire

[design/fqp_out_if.sv]
// Result channel of the FASTQ record parser: kind, character and
// length-mismatch flag per beat, valid/ready handshake. No dependencies.
`default_nettype none

interface fqp_out_if;
    logic valid;
    logic ready;
    logic [2:0] kind;
    logic [7:0] char_out;
    logic length_mismatch;

    modport source (output valid, output kind, output char_out, output length_mismatch,
                    input ready);
    modport sink (input valid, input kind, input char_out, input length_mismatch,
                  output ready);
endinterface

`default_nettype wire

[design/fqp_out_stage.sv]
// Result register of the FASTQ record parser: holds one result beat
// until the sink takes it. Depends on fqp_pkg and fqp_out_if.
`default_nettype none

module fqp_out_stage (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  fqp_pkg::t_res_beat i_beat,
    output logic               o_free,
    fqp_out_if.source          o_out
);

    logic r_valid;
    fqp_pkg::t_kind r_kind;
    logic [7:0] r_char;
    logic r_mismatch;

    // Free when empty or when the held beat leaves this cycle
    assign o_free = !r_valid || o_out.ready;

    // Load a new beat whenever the register is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_beat.valid;
        end
        if (o_free && i_beat.valid) begin
            r_kind <= i_beat.kind;
            r_char <= i_beat.char_out;
            r_mismatch <= i_beat.length_mismatch;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.kind = r_kind;
    assign o_out.char_out = r_char;
    assign o_out.length_mismatch = r_mismatch;

endmodule

`default_nettype wire

[design/fqp_parse_core.sv]
// Input register and record state machine of the FASTQ record parser.
// Classifies each byte and tracks sequence and quality lengths.
// Depends on fqp_pkg and fqp_in_if.
`default_nettype none

module fqp_parse_core #(
    parameter int LENGTH_BITS = fqp_pkg::LENGTH_BITS_DEF
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    fqp_in_if.sink             i_in,
    input  wire                logic i_out_free,
    output fqp_pkg::t_res_beat o_beat
);

    typedef enum logic [3:0] {
        P_FIRST = 4'd0,
        P_SKIP_FIRST = 4'd1,
        P_SKIP_FIRST_NL = 4'd2,
        P_ID = 4'd3,
        P_ID_NL = 4'd4,
        P_SEQ = 4'd5,
        P_SEQ_NL = 4'd6,
        P_PLUS = 4'd7,
        P_PLUS_NL = 4'd8,
        P_QUAL = 4'd9,
        P_BETWEEN = 4'd10,
        P_STOPPED = 4'd11
    } t_phase;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    logic r_s1_valid;
    logic [7:0] r_byte;
    logic r_eoi;
    t_phase r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_seq_len, n_seq_len;
    logic [LENGTH_BITS-1:0] r_qual_len, n_qual_len;

    logic advance;
    logic is_eol;
    logic emit;
    fqp_pkg::t_kind kind;
    logic [7:0] ch;
    logic mismatch;

    function automatic logic [LENGTH_BITS-1:0] bump(input logic [LENGTH_BITS-1:0] v);
        bump = (v == LEN_MAX) ? v : v + LENGTH_BITS'(1);
    endfunction

    // Take a byte when the input register is empty or drains this cycle
    assign advance = r_s1_valid && i_out_free;
    assign i_in.ready = !r_s1_valid || i_out_free;

    assign is_eol = (r_byte == fqp_pkg::CH_LF) || (r_byte == fqp_pkg::CH_CR);

    // Decode the held byte against the current phase
    always_comb begin
        n_phase = r_phase;
        n_seq_len = r_seq_len;
        n_qual_len = r_qual_len;
        emit = 1'b0;
        kind = fqp_pkg::K_ID;
        ch = 8'h00;
        mismatch = 1'b0;
        if (r_phase == P_STOPPED) begin
            n_phase = P_STOPPED;
        end else if (r_eoi) begin
            n_phase = P_STOPPED;
            emit = 1'b1;
            kind = (r_phase == P_BETWEEN) ? fqp_pkg::K_DONE : fqp_pkg::K_ERR;
        end else begin
            case (r_phase)
                P_FIRST: begin
                    if (is_eol) begin
                        n_phase = P_SKIP_FIRST_NL;
                    end else if (r_byte == fqp_pkg::CH_AT) begin
                        n_phase = P_ID;
                    end else begin
                        n_phase = P_SKIP_FIRST;
                    end
                end
                P_SKIP_FIRST: begin
                    if (is_eol) begin
                        n_phase = P_SKIP_FIRST_NL;
                    end
                end
                P_SKIP_FIRST_NL: begin
                    if (!is_eol) begin
                        if (r_byte == fqp_pkg::CH_AT) begin
                            n_phase = P_ID;
                        end else begin
                            n_phase = P_STOPPED;
                            emit = 1'b1;
                            kind = fqp_pkg::K_ERR;
                        end
                    end
                end
                P_BETWEEN: begin
                    if (!is_eol) begin
                        n_phase = P_ID;
                        if (r_byte != fqp_pkg::CH_AT) begin
                            emit = 1'b1;
                            kind = fqp_pkg::K_ID;
                            ch = r_byte;
                        end
                    end
                end
                P_ID: begin
                    if (is_eol) begin
                        n_phase = P_ID_NL;
                    end else if (r_byte != fqp_pkg::CH_AT) begin
                        emit = 1'b1;
                        kind = fqp_pkg::K_ID;
                        ch = r_byte;
                    end
                end
                P_ID_NL, P_SEQ: begin
                    if (is_eol) begin
                        if (r_phase == P_SEQ) begin
                            n_phase = P_SEQ_NL;
                        end
                    end else begin
                        n_phase = P_SEQ;
                        n_seq_len = bump(r_seq_len);
                        emit = 1'b1;
                        kind = fqp_pkg::K_SEQ;
                        ch = (r_byte inside {[fqp_pkg::CH_LOWER_A:fqp_pkg::CH_LOWER_Z]})
                            ? r_byte - fqp_pkg::CASE_OFFSET : r_byte;
                    end
                end
                P_SEQ_NL: begin
                    if (!is_eol) begin
                        if (r_byte == fqp_pkg::CH_PLUS) begin
                            n_phase = P_PLUS;
                        end else begin
                            n_phase = P_STOPPED;
                            emit = 1'b1;
                            kind = fqp_pkg::K_ERR;
                        end
                    end
                end
                P_PLUS: begin
                    if (is_eol) begin
                        n_phase = P_PLUS_NL;
                    end
                end
                P_PLUS_NL: begin
                    if (!is_eol) begin
                        n_phase = P_QUAL;
                        n_qual_len = bump(r_qual_len);
                        emit = 1'b1;
                        kind = fqp_pkg::K_QUAL;
                        ch = r_byte;
                    end
                end
                P_QUAL: begin
                    if (is_eol) begin
                        n_phase = P_BETWEEN;
                        n_seq_len = '0;
                        n_qual_len = '0;
                        emit = 1'b1;
                        kind = fqp_pkg::K_END;
                        mismatch = (r_qual_len != r_seq_len);
                    end else begin
                        n_qual_len = bump(r_qual_len);
                        emit = 1'b1;
                        kind = fqp_pkg::K_QUAL;
                        ch = r_byte;
                    end
                end
                default: begin
                    n_phase = P_STOPPED;
                end
            endcase
        end
    end

    // Hold the input byte and advance the record state as it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_phase <= P_FIRST;
            r_seq_len <= '0;
            r_qual_len <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_seq_len <= n_seq_len;
                r_qual_len <= n_qual_len;
            end
        end
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.byte_in;
            r_eoi <= i_in.end_of_input;
        end
    end

    assign o_beat.valid = advance && emit;
    assign o_beat.kind = kind;
    assign o_beat.char_out = ch;
    assign o_beat.length_mismatch = mismatch;

endmodule

`default_nettype wire

[design/fastq_record_parser.sv]
// FASTQ record parser: one byte accepted per cycle while results drain.
// Path: a result passes through the input register, then the result
// register; bytes that give no result drop.
// Throughput: one byte per cycle while the result register is free.
// Reset: synchronous, active low; clears phase to "expect first '@'",
// both length counters and both pipeline valid flags.
`default_nettype none

module fastq_record_parser #(
    parameter int LENGTH_BITS = fqp_pkg::LENGTH_BITS_DEF
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    fqp_in_if.sink    i_in,
    fqp_out_if.source o_out
);

    fqp_pkg::t_res_beat beat;
    logic out_free;

    // Classify bytes and track record state
    fqp_parse_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_out_free (out_free),
        .o_beat     (beat)
    );

    // Hold results until the sink takes them
    fqp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    // No result follows a delivered error
    a_quiet_after_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.kind == fqp_pkg::K_ERR) |=> !o_out.valid)
        else $error("result after error");

    // Sequence characters leave uppercased
    a_seq_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == fqp_pkg::K_SEQ) |->
        (o_out.char_out < fqp_pkg::CH_LOWER_A || o_out.char_out > fqp_pkg::CH_LOWER_Z))
        else $error("lowercase sequence character");

    // Mismatch flag only on record end
    a_mm_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != fqp_pkg::K_END) |-> !o_out.length_mismatch)
        else $error("mismatch flag outside record end");

endmodule

`default_nettype wire
